// ===== rtl/ssus_pkg.sv =====
package ssus_pkg;

  localparam int unsigned DEC_W    = 4;
  localparam int unsigned CHANNELS = 4;

  localparam logic [3:0] CMD_LAST = 4'd10;

  localparam logic [7:0] CHR_A    = 8'h41;
  localparam logic [7:0] CHR_ONE  = 8'h31;
  localparam logic [7:0] CHR_LA   = 8'h61;
  localparam logic [7:0] CHR_ZERO = 8'h30;
  localparam logic [7:0] CHR_NL   = 8'h0a;

  typedef enum logic [1:0] {
    ACT_SET    = 2'd0,
    ACT_NEXT   = 2'd1,
    ACT_REPEAT = 2'd2
  } action_t;

  typedef struct packed {
    logic [1:0] action;
    logic [3:0] decoder_address;
    logic [1:0] channel_index;
    logic [1:0] signal_level;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
    logic       level_changed;
  } out_t;

  typedef logic [CHANNELS-1:0][1:0] row_t;

  // one work item between front and back
  typedef struct packed {
    logic             is_cmd;
    logic             level_changed;
    logic [DEC_W-1:0] dec;
    row_t             lv;
  } qent_t;

endpackage

// ===== rtl/ssus_front.sv =====
module ssus_front
  import ssus_pkg::*;
#(
  parameter int unsigned DECODERS = 8
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  in_t   in_data,
  input  logic  q_full,
  output logic  q_push,
  output qent_t q_data
);

  localparam int unsigned IDX_W = (DECODERS > 1) ? $clog2(DECODERS) : 1;

  row_t                lvl_r [DECODERS];
  logic [DECODERS-1:0] dirty_r, dirty_nxt;
  logic [DEC_W-1:0]    rpt_r, rpt_nxt;

  logic             accept;
  logic             in_range;
  logic [DEC_W-1:0] set_dec;
  logic [DEC_W-1:0] first_dec;
  logic             any_dirty;
  logic [DEC_W-1:0] rd_dec;
  row_t             rd_row;
  logic             wr_en;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept;

  assign in_range = (in_data.decoder_address != '0) &&
                    (in_data.decoder_address <= DEC_W'(DECODERS));
  assign set_dec  = in_data.decoder_address - DEC_W'(1);

  always_comb begin
    first_dec = '0;
    for (int i = DECODERS - 1; i >= 0; i--) begin
      if (dirty_r[i]) first_dec = DEC_W'(i);
    end
  end
  assign any_dirty = |dirty_r;

  always_comb begin
    case (in_data.action)
      ACT_SET:  rd_dec = set_dec;
      ACT_NEXT: rd_dec = first_dec;
      default:  rd_dec = rpt_r;
    endcase
  end

  assign rd_row = lvl_r[rd_dec[IDX_W-1:0]];

  always_comb begin
    q_data               = '0;
    q_data.dec           = rd_dec;
    q_data.lv            = rd_row;
    dirty_nxt            = dirty_r;
    rpt_nxt              = rpt_r;
    wr_en                = 1'b0;
    case (in_data.action)
      ACT_SET: begin
        if (in_range && (rd_row[in_data.channel_index] != in_data.signal_level)) begin
          wr_en                       = accept;
          q_data.level_changed        = 1'b1;
          dirty_nxt[set_dec[IDX_W-1:0]] = 1'b1;
        end
      end
      ACT_NEXT: begin
        if (any_dirty) begin
          q_data.is_cmd                   = 1'b1;
          dirty_nxt[first_dec[IDX_W-1:0]] = 1'b0;
        end
      end
      ACT_REPEAT: begin
        q_data.is_cmd = 1'b1;
        rpt_nxt = (rpt_r == DEC_W'(DECODERS - 1)) ? '0 : rpt_r + DEC_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dirty_r <= '0;
      rpt_r   <= '0;
      for (int i = 0; i < DECODERS; i++) lvl_r[i] <= '0;
    end else begin
      if (accept) begin
        dirty_r <= dirty_nxt;
        rpt_r   <= rpt_nxt;
      end
      if (wr_en) lvl_r[set_dec[IDX_W-1:0]][in_data.channel_index] <= in_data.signal_level;
    end
  end

endmodule

// ===== rtl/ssus_fifo.sv =====
module ssus_fifo
  import ssus_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  qent_t push_data,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output qent_t head_data
);

  qent_t      ent_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_data  = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) ent_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== rtl/ssus_back.sv =====
module ssus_back
  import ssus_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  head_valid,
  input  qent_t head_data,
  output logic  pop,
  output logic  out_valid,
  input  logic  out_stall,
  output out_t  out_data
);

  logic [3:0] idx_r;
  logic       out_valid_r;
  out_t       out_data_r;

  logic       load;
  out_t       cur;
  logic [3:0] idx_m2;

  assign idx_m2 = idx_r - 4'd2;

  always_comb begin
    cur = '0;
    if (!head_data.is_cmd) begin
      cur.last_byte     = 1'b1;
      cur.level_changed = head_data.level_changed;
    end else if (idx_r == 4'd0) begin
      cur.out_byte = CHR_A;
    end else if (idx_r == 4'd1) begin
      cur.out_byte = CHR_ONE + 8'(head_data.dec);
    end else if (idx_r == CMD_LAST) begin
      cur.out_byte  = CHR_NL;
      cur.last_byte = 1'b1;
    end else if (!idx_r[0]) begin
      cur.out_byte = CHR_LA + 8'(idx_m2[2:1]);
    end else begin
      cur.out_byte = CHR_ZERO + 8'(head_data.lv[idx_m2[2:1]]);
    end
  end

  assign load      = head_valid && (!out_valid_r || !out_stall);
  assign pop       = load && cur.last_byte;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (load) out_data_r <= cur;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        idx_r       <= cur.last_byte ? 4'd0 : idx_r + 4'd1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // position never runs past the newline
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= CMD_LAST)
    else $error("byte position out of range");

  // a part-sent command keeps its queue entry
  a_mid_cmd_head: assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r != 4'd0) |-> (head_valid && head_data.is_cmd))
    else $error("command entry lost mid-transfer");

  // an entry leaves only after its last byte went to the output register
  a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (out_valid && out_data.last_byte))
    else $error("entry retired without last byte");

endmodule

// ===== rtl/signal_shadow_update_scheduler_core.sv =====
// Signal shadow update scheduler.
// Input channel (in_valid / in_stall / in_data): one action per transfer:
//   set level, request next dirty command, or request repeat command.
// Output channel (out_valid / out_stall / out_data): one byte per transfer.
//   A set action (and an idle next request or unused code) yields one
//   transfer with last_byte set; a command yields eleven, 'A', decoder
//   digit, a..d with level digits, newline, last_byte on the newline.
// Path: an action is written into the queue, then its first byte into the
//   output register. Throughput: one output byte per cycle while out_stall
//   is low and the queue holds an entry; the byte serialiser in the back
//   end sets this rate.
// The front end updates the level table, dirty flags and repeat pointer at
//   once and hands a snapshot of the chosen decoder's row to a two-entry
//   queue, so it keeps taking actions while the back end is still sending.
// Reset (rst_n low, synchronous): all levels zero, dirty flags clear,
//   repeat pointer zero, queue and output empty.
// Receiver stall: the output byte holds; the queue fills, after which
//   in_stall rises until the back end drains an entry.
module signal_shadow_update_scheduler_core
  import ssus_pkg::*;
#(
  parameter int unsigned DECODERS = 8
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  logic  q_push, q_full, q_pop, q_valid;
  qent_t q_wdata, q_head;

  // front: state owner, classifies each action
  ssus_front #(
    .DECODERS (DECODERS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  // decoupling queue
  ssus_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_wdata),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_head)
  );

  // back: byte serialiser with output register
  ssus_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_valid),
    .head_data  (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
